### hdl/raft_election_node_core_assert.svh
// Assertion macros shared by the raft election node checks.
`ifndef RAFT_ELECTION_NODE_CORE_ASSERT_SVH
`define RAFT_ELECTION_NODE_CORE_ASSERT_SVH

// Check on the running clock, quiet while reset is high.
`define RLE_ASSERT_CLK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rle check failed");

// Check that also covers cycles in and right after reset.
`define RLE_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("rle reset check failed");

`endif

### hdl/rle_pkg.sv
// Shared types, constants and control structs of the raft election node core.
package rle_pkg;

   // Field widths fixed by the channel format
   localparam int MODE_W      = 3;
   localparam int TERM_PORT_W = 32;
   localparam int NODE_W      = 4;
   localparam int MCOUNT_W    = 5;
   localparam int KIND_W      = 2;
   localparam int ROLE_W      = 2;
   localparam int VOTE_W      = 5;
   localparam int TIMER_W     = 4;
   localparam int RNG_W       = 64;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_NODES  = 16;
   localparam int DEF_TERM_WIDTH = 32;

   // Reset values of the configuration registers
   localparam logic [MCOUNT_W-1:0] MCOUNT_RESET = MCOUNT_W'(5);

   // Vote register code for "no vote"
   localparam logic [VOTE_W-1:0] NO_VOTE = {VOTE_W{1'b1}};

   // Election timer
   localparam logic [TIMER_W-1:0] TIMER_MAX    = {TIMER_W{1'b1}};
   localparam logic [TIMER_W-1:0] TIMEOUT_BASE = TIMER_W'(6);

   // splitmix64 constants
   localparam logic [RNG_W-1:0] SM_GAMMA = 64'h9E3779B97F4A7C15;
   localparam logic [RNG_W-1:0] SM_MUL1  = 64'hBF58476D1CE4E5B9;
   localparam logic [RNG_W-1:0] SM_MUL2  = 64'h94D049BB133111EB;

   // Event codes of the request channel
   typedef enum logic [MODE_W-1:0] {
      MODE_START   = 3'd0,
      MODE_TICK    = 3'd1,
      MODE_REQVOTE = 3'd2,
      MODE_VOTEREP = 3'd3,
      MODE_HBEAT   = 3'd4,
      MODE_CRASH   = 3'd5
   } mode_type;

   typedef enum logic [ROLE_W-1:0] {
      ROLE_FOL  = 2'd0,
      ROLE_CAND = 2'd1,
      ROLE_LEAD = 2'd2
   } role_type;

   typedef enum logic [KIND_W-1:0] {
      SEND_NONE    = 2'd0,
      SEND_VOTEREP = 2'd1,
      SEND_HBEAT   = 2'd2,
      SEND_REQVOTE = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NODE_ID  = 2'd0,
      CSR_MCOUNT   = 2'd1,
      CSR_KEEPVOTE = 2'd2,
      CSR_RNGSEED  = 2'd3
   } csr_idx_type;

   // Multiplier phases: low x low, high x low, low x high
   typedef enum logic [1:0] {
      MUL_LL = 2'd0,
      MUL_HL = 2'd1,
      MUL_LH = 2'd2
   } mul_phase_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic          load_item;
      logic          exec;
      logic          tally;
      logic          rng_add;
      logic          rng_mul;
      mul_phase_type mul_phase;
      logic          mul_pass;
      logic          rng_mix;
      logic          rng_fin;
      logic          rng_mod;
      logic          load_rsp;
   } rle_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic need_rearm;
      logic need_tally;
   } rle_stat_type;

endpackage

### hdl/rle_if.sv
// Request and response channel interfaces of the raft election node core.
interface rle_req_if;
   import rle_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [MODE_W-1:0]      mode;
   logic [TERM_PORT_W-1:0] msg_term;
   logic [NODE_W-1:0]      msg_node;
   logic                   msg_granted;

   modport source (output valid, output mode, output msg_term, output msg_node,
                   output msg_granted, input ready);
   modport sink   (input valid, input mode, input msg_term, input msg_node,
                   input msg_granted, output ready);
endinterface

interface rle_rsp_if;
   import rle_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        send_kind;
   logic [TERM_PORT_W-1:0]   send_term;
   logic [NODE_W-1:0]        send_dest;
   logic                     send_granted;
   logic                     report_valid;
   logic                     alive;
   logic [TERM_PORT_W-1:0]   term_now;
   logic [ROLE_W-1:0]        role_now;
   logic signed [VOTE_W-1:0] vote_now;

   modport source (output valid, output send_kind, output send_term, output send_dest,
                   output send_granted, output report_valid, output alive,
                   output term_now, output role_now, output vote_now, input ready);
   modport sink   (input valid, input send_kind, input send_term, input send_dest,
                   input send_granted, input report_valid, input alive,
                   input term_now, input role_now, input vote_now, output ready);
endinterface

### hdl/rle_ctrl.sv
// Sequencing state machine of the raft election node core.
module rle_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   input  rle_pkg::rle_stat_type stat,
   output rle_pkg::rle_cmd_type  cmd
);
   import rle_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_EXEC  = 9'b000000010,
      ST_TALLY = 9'b000000100,
      ST_RADD  = 9'b000001000,
      ST_RMUL  = 9'b000010000,
      ST_RMIX  = 9'b000100000,
      ST_RFIN  = 9'b001000000,
      ST_RMOD  = 9'b010000000,
      ST_DONE  = 9'b100000000
   } rle_state_type;

   rle_state_type state_ff, state_in;
   mul_phase_type phase_ff, phase_in;
   logic          pass_ff, pass_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   // Output slot frees up when empty or when the current transaction is taken
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and command decode
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      pass_in       = pass_ff;
      cmd           = '0;
      cmd.mul_phase = phase_ff;
      cmd.mul_pass  = pass_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_item = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.need_tally) begin
               state_in = ST_TALLY;
            end else if (stat.need_rearm) begin
               state_in = ST_RADD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_TALLY: begin
            cmd.tally = 1'b1;
            state_in  = ST_DONE;
         end
         ST_RADD: begin
            cmd.rng_add = 1'b1;
            phase_in    = MUL_LL;
            pass_in     = 1'b0;
            state_in    = ST_RMUL;
         end
         ST_RMUL: begin
            cmd.rng_mul = 1'b1;
            case (phase_ff)
               MUL_LL:  phase_in = MUL_HL;
               MUL_HL:  phase_in = MUL_LH;
               default: begin
                  phase_in = MUL_LL;
                  state_in = pass_ff ? ST_RFIN : ST_RMIX;
               end
            endcase
         end
         ST_RMIX: begin
            cmd.rng_mix = 1'b1;
            pass_in     = 1'b1;
            state_in    = ST_RMUL;
         end
         ST_RFIN: begin
            cmd.rng_fin = 1'b1;
            state_in    = ST_RMOD;
         end
         ST_RMOD: begin
            cmd.rng_mod = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            cmd.load_rsp = slot_free;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid flag
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= MUL_LL;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/rle_dp.sv
// Election state, event evaluation, vote tally and timeout generator.
module rle_dp #(
   parameter int MAX_NODES  = rle_pkg::DEF_MAX_NODES,
   parameter int TERM_WIDTH = rle_pkg::DEF_TERM_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration writes
   input  logic                                 csr_wr_en,
   input  logic [rle_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rle_pkg::CSR_DATA_W-1:0]       csr_wr_data,
   // request payload
   input  logic [rle_pkg::MODE_W-1:0]           in_mode,
   input  logic [rle_pkg::TERM_PORT_W-1:0]      in_msg_term,
   input  logic [rle_pkg::NODE_W-1:0]           in_msg_node,
   input  logic                                 in_msg_granted,
   // response payload
   output logic [rle_pkg::KIND_W-1:0]           out_send_kind,
   output logic [rle_pkg::TERM_PORT_W-1:0]      out_send_term,
   output logic [rle_pkg::NODE_W-1:0]           out_send_dest,
   output logic                                 out_send_granted,
   output logic                                 out_report_valid,
   output logic                                 out_alive,
   output logic [rle_pkg::TERM_PORT_W-1:0]      out_term_now,
   output logic [rle_pkg::ROLE_W-1:0]           out_role_now,
   output logic signed [rle_pkg::VOTE_W-1:0]    out_vote_now,
   // controller link
   input  rle_pkg::rle_cmd_type                 cmd,
   output rle_pkg::rle_stat_type                stat
);
   import rle_pkg::*;

   localparam int CMP_W = (TERM_WIDTH > TERM_PORT_W) ? TERM_WIDTH : TERM_PORT_W;
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam logic [TERM_WIDTH-1:0] TERM_MAX = {TERM_WIDTH{1'b1}};

   // configuration registers
   logic [NODE_W-1:0]   cfg_node_id_ff, cfg_node_id_in;
   logic [MCOUNT_W-1:0] cfg_mcount_ff, cfg_mcount_in;
   logic                cfg_keep_ff, cfg_keep_in;

   // latched transaction
   logic [MODE_W-1:0]     item_mode_ff, item_mode_in;
   logic [TERM_WIDTH-1:0] item_term_ff, item_term_in;
   logic [NODE_W-1:0]     item_node_ff, item_node_in;
   logic                  item_grant_ff, item_grant_in;

   // election state
   logic [TERM_WIDTH-1:0] term_ff, term_in;
   logic [VOTE_W-1:0]     voted_ff, voted_in;
   role_type              role_ff, role_in;
   logic [MAX_NODES-1:0]  marks_ff, marks_in;
   logic [TIMER_W-1:0]    timer_ff, timer_in;
   logic [TIMER_W-1:0]    timeout_ff, timeout_in;

   // generator
   logic [RNG_W-1:0] rng_ff, rng_in;
   logic [RNG_W-1:0] mul_a_ff, mul_a_in;
   logic [RNG_W-1:0] acc_ff, acc_in;
   logic [17:0]      fold_ff, fold_in;

   // pending result fields
   kind_type              res_kind_ff, res_kind_in;
   logic [TERM_WIDTH-1:0] res_sterm_ff, res_sterm_in;
   logic [NODE_W-1:0]     res_dest_ff, res_dest_in;
   logic                  res_grant_ff, res_grant_in;
   logic                  res_rvalid_ff, res_rvalid_in;
   logic                  res_alive_ff, res_alive_in;

   // output register
   logic [KIND_W-1:0]      rsp_kind_ff, rsp_kind_in;
   logic [TERM_PORT_W-1:0] rsp_sterm_ff, rsp_sterm_in;
   logic [NODE_W-1:0]      rsp_dest_ff, rsp_dest_in;
   logic                   rsp_grant_ff, rsp_grant_in;
   logic                   rsp_rvalid_ff, rsp_rvalid_in;
   logic                   rsp_alive_ff, rsp_alive_in;
   logic [TERM_PORT_W-1:0] rsp_term_ff, rsp_term_in;
   logic [ROLE_W-1:0]      rsp_role_ff, rsp_role_in;
   logic [VOTE_W-1:0]      rsp_vote_ff, rsp_vote_in;

   // combinational helpers
   logic [CMP_W-1:0]     mt_wide;
   logic [CMP_W-1:0]     mt_sat;
   logic [TIMER_W-1:0]   timer_inc;
   logic                 timer_fire;
   logic [MAX_NODES-1:0] own_bit;
   logic [MAX_NODES-1:0] msg_bit;
   logic [MAX_NODES-1:0] count_mask;
   logic [CNT_W-1:0]     tally_cnt;
   logic                 tally_win;
   logic                 grant;
   logic [RNG_W-1:0]     rng_sum;
   logic [31:0]          op_a;
   logic [31:0]          op_c;
   logic [RNG_W-1:0]     mul_const;
   logic [RNG_W-1:0]     prod;
   logic [RNG_W-1:0]     mix_z;
   logic [32:0]          fold_a;
   logic [17:0]          fold_b;
   logic [10:0]          fold_c;
   logic [7:0]           fold_d;
   logic [6:0]           fold_e;
   logic [4:0]           fold_f;
   logic [3:0]           fold_g;
   logic [2:0]           fold_h;
   logic [1:0]           rnd_mod3;

   // Incoming term saturates to the largest stored term
   assign mt_wide = CMP_W'(in_msg_term);
   assign mt_sat  = (mt_wide > CMP_W'(TERM_MAX)) ? CMP_W'(TERM_MAX) : mt_wide;

   assign timer_inc  = (timer_ff < TIMER_MAX) ? timer_ff + TIMER_W'(1) : timer_ff;
   assign timer_fire = (timer_inc >= timeout_ff);

   // Mark decode and member mask
   always_comb begin
      for (int k = 0; k < MAX_NODES; k++) begin
         own_bit[k]    = (32'(cfg_node_id_ff) == k);
         msg_bit[k]    = (32'(item_node_ff) == k);
         count_mask[k] = (32'(cfg_mcount_ff) > k);
      end
   end

   // Majority check over the counted marks
   assign tally_cnt = CNT_W'($countones(marks_ff & count_mask));
   assign tally_win = ((32'(tally_cnt) << 1) > 32'(cfg_mcount_ff));

   // Shared 32x32 multiplier, three partial products per 64-bit product
   assign mul_const = cmd.mul_pass ? SM_MUL2 : SM_MUL1;
   assign op_a      = (cmd.mul_phase == MUL_HL) ? mul_a_ff[63:32] : mul_a_ff[31:0];
   assign op_c      = (cmd.mul_phase == MUL_LH) ? mul_const[63:32] : mul_const[31:0];
   assign prod      = RNG_W'(op_a) * RNG_W'(op_c);

   assign rng_sum = rng_ff + SM_GAMMA;

   // Final mix and first folds of the mod-3 reduction (2^16 and 2^32 are 1 mod 3)
   assign mix_z  = acc_ff ^ (acc_ff >> 31);
   assign fold_a = {1'b0, mix_z[63:32]} + {1'b0, mix_z[31:0]};
   assign fold_b = 18'(fold_a[32:16]) + 18'(fold_a[15:0]);

   // Remaining narrow folds
   assign fold_c   = 11'(fold_ff[17:8]) + 11'(fold_ff[7:0]);
   assign fold_d   = 8'(fold_c[10:4]) + 8'(fold_c[3:0]);
   assign fold_e   = 7'(fold_d[7:2]) + 7'(fold_d[1:0]);
   assign fold_f   = 5'(fold_e[6:4]) + 5'(fold_e[3:0]);
   assign fold_g   = 4'(fold_f[4:2]) + 4'(fold_f[1:0]);
   assign fold_h   = 3'(fold_g[3:2]) + 3'(fold_g[1:0]);
   assign rnd_mod3 = (fold_h >= 3'd3) ? 2'(fold_h - 3'd3) : fold_h[1:0];

   // Next-state logic
   always_comb begin
      cfg_node_id_in = cfg_node_id_ff;
      cfg_mcount_in  = cfg_mcount_ff;
      cfg_keep_in    = cfg_keep_ff;
      item_mode_in   = item_mode_ff;
      item_term_in   = item_term_ff;
      item_node_in   = item_node_ff;
      item_grant_in  = item_grant_ff;
      term_in        = term_ff;
      voted_in       = voted_ff;
      role_in        = role_ff;
      marks_in       = marks_ff;
      timer_in       = timer_ff;
      timeout_in     = timeout_ff;
      rng_in         = rng_ff;
      mul_a_in       = mul_a_ff;
      acc_in         = acc_ff;
      fold_in        = fold_ff;
      res_kind_in    = res_kind_ff;
      res_sterm_in   = res_sterm_ff;
      res_dest_in    = res_dest_ff;
      res_grant_in   = res_grant_ff;
      res_rvalid_in  = res_rvalid_ff;
      res_alive_in   = res_alive_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_sterm_in   = rsp_sterm_ff;
      rsp_dest_in    = rsp_dest_ff;
      rsp_grant_in   = rsp_grant_ff;
      rsp_rvalid_in  = rsp_rvalid_ff;
      rsp_alive_in   = rsp_alive_ff;
      rsp_term_in    = rsp_term_ff;
      rsp_role_in    = rsp_role_ff;
      rsp_vote_in    = rsp_vote_ff;
      stat           = '0;
      grant          = 1'b0;

      // configuration write; the seed also reloads the generator
      if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_NODE_ID:  cfg_node_id_in = csr_wr_data[NODE_W-1:0];
            CSR_MCOUNT:   cfg_mcount_in  = csr_wr_data[MCOUNT_W-1:0];
            CSR_KEEPVOTE: cfg_keep_in    = csr_wr_data[0];
            CSR_RNGSEED:  rng_in         = csr_wr_data[RNG_W-1:0];
            default:      cfg_keep_in    = cfg_keep_ff;
         endcase
      end

      // capture the accepted transaction
      if (cmd.load_item) begin
         item_mode_in  = in_mode;
         item_term_in  = TERM_WIDTH'(mt_sat);
         item_node_in  = in_msg_node;
         item_grant_in = in_msg_granted;
      end

      // event evaluation
      if (cmd.exec) begin
         res_kind_in   = SEND_NONE;
         res_sterm_in  = '0;
         res_dest_in   = '0;
         res_grant_in  = 1'b0;
         res_rvalid_in = 1'b0;
         res_alive_in  = 1'b1;
         case (mode_type'(item_mode_ff))
            MODE_START: begin
               timer_in        = '0;
               stat.need_rearm = 1'b1;
            end
            MODE_TICK: begin
               res_rvalid_in = 1'b1;
               if (role_ff == ROLE_LEAD) begin
                  res_kind_in  = SEND_HBEAT;
                  res_sterm_in = term_ff;
               end else begin
                  timer_in = timer_inc;
                  if (timer_fire) begin
                     term_in         = (term_ff == TERM_MAX) ? term_ff
                                                             : term_ff + TERM_WIDTH'(1);
                     voted_in        = {1'b0, cfg_node_id_ff};
                     role_in         = ROLE_CAND;
                     marks_in        = own_bit;
                     timer_in        = '0;
                     stat.need_rearm = 1'b1;
                  end
                  if (role_in == ROLE_CAND) begin
                     res_kind_in  = SEND_REQVOTE;
                     res_sterm_in = term_in;
                  end
               end
            end
            MODE_REQVOTE: begin
               if (item_term_ff > term_ff) begin
                  term_in  = item_term_ff;
                  voted_in = NO_VOTE;
                  role_in  = ROLE_FOL;
                  marks_in = '0;
               end
               grant = (item_term_ff == term_in) &&
                       ((voted_in == NO_VOTE) || (voted_in == {1'b0, item_node_ff}));
               if (grant) begin
                  voted_in        = {1'b0, item_node_ff};
                  timer_in        = '0;
                  stat.need_rearm = 1'b1;
               end
               res_kind_in  = SEND_VOTEREP;
               res_sterm_in = term_in;
               res_dest_in  = item_node_ff;
               res_grant_in = grant;
            end
            MODE_VOTEREP: begin
               if (item_term_ff > term_ff) begin
                  term_in  = item_term_ff;
                  voted_in = NO_VOTE;
                  role_in  = ROLE_FOL;
                  marks_in = '0;
               end else if ((role_ff == ROLE_CAND) && (item_term_ff == term_ff) &&
                            item_grant_ff) begin
                  marks_in        = marks_ff | msg_bit;
                  stat.need_tally = 1'b1;
               end
            end
            MODE_HBEAT: begin
               if (item_term_ff > term_ff) begin
                  term_in  = item_term_ff;
                  voted_in = NO_VOTE;
                  role_in  = ROLE_FOL;
                  marks_in = '0;
               end
               if ((item_term_ff == term_in) && (role_in != ROLE_LEAD)) begin
                  role_in         = ROLE_FOL;
                  timer_in        = '0;
                  stat.need_rearm = 1'b1;
               end
            end
            MODE_CRASH: begin
               if (!cfg_keep_ff) begin
                  voted_in = NO_VOTE;
               end
               role_in         = ROLE_FOL;
               marks_in        = '0;
               timer_in        = '0;
               stat.need_rearm = 1'b1;
               res_rvalid_in   = 1'b1;
               res_alive_in    = 1'b0;
            end
            default: begin
               res_kind_in = SEND_NONE;
            end
         endcase
      end

      // majority reached: take the lead and announce it
      if (cmd.tally && tally_win) begin
         role_in      = ROLE_LEAD;
         res_kind_in  = SEND_HBEAT;
         res_sterm_in = term_ff;
      end

      // generator sequence
      if (cmd.rng_add) begin
         rng_in   = rng_sum;
         mul_a_in = rng_sum ^ (rng_sum >> 30);
      end
      if (cmd.rng_mul) begin
         case (cmd.mul_phase)
            MUL_LL:  acc_in = prod;
            default: acc_in = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
         endcase
      end
      if (cmd.rng_mix) begin
         mul_a_in = acc_ff ^ (acc_ff >> 27);
      end
      if (cmd.rng_fin) begin
         fold_in = fold_b;
      end
      if (cmd.rng_mod) begin
         timeout_in = TIMEOUT_BASE + TIMER_W'(rnd_mod3);
      end

      // load the output register
      if (cmd.load_rsp) begin
         rsp_kind_in   = res_kind_ff;
         rsp_sterm_in  = TERM_PORT_W'(res_sterm_ff);
         rsp_dest_in   = res_dest_ff;
         rsp_grant_in  = res_grant_ff;
         rsp_rvalid_in = res_rvalid_ff;
         rsp_alive_in  = res_alive_ff;
         rsp_term_in   = TERM_PORT_W'(term_ff);
         rsp_role_in   = role_ff;
         rsp_vote_in   = voted_ff;
      end
   end

   // Architectural state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_node_id_ff <= '0;
         cfg_mcount_ff  <= MCOUNT_RESET;
         cfg_keep_ff    <= 1'b0;
         term_ff        <= '0;
         voted_ff       <= NO_VOTE;
         role_ff        <= ROLE_FOL;
         marks_ff       <= '0;
         timer_ff       <= '0;
         timeout_ff     <= '0;
         rng_ff         <= '0;
      end else begin
         cfg_node_id_ff <= cfg_node_id_in;
         cfg_mcount_ff  <= cfg_mcount_in;
         cfg_keep_ff    <= cfg_keep_in;
         term_ff        <= term_in;
         voted_ff       <= voted_in;
         role_ff        <= role_in;
         marks_ff       <= marks_in;
         timer_ff       <= timer_in;
         timeout_ff     <= timeout_in;
         rng_ff         <= rng_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_mode_ff  <= item_mode_in;
      item_term_ff  <= item_term_in;
      item_node_ff  <= item_node_in;
      item_grant_ff <= item_grant_in;
      mul_a_ff      <= mul_a_in;
      acc_ff        <= acc_in;
      fold_ff       <= fold_in;
      res_kind_ff   <= res_kind_in;
      res_sterm_ff  <= res_sterm_in;
      res_dest_ff   <= res_dest_in;
      res_grant_ff  <= res_grant_in;
      res_rvalid_ff <= res_rvalid_in;
      res_alive_ff  <= res_alive_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_sterm_ff  <= rsp_sterm_in;
      rsp_dest_ff   <= rsp_dest_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_rvalid_ff <= rsp_rvalid_in;
      rsp_alive_ff  <= rsp_alive_in;
      rsp_term_ff   <= rsp_term_in;
      rsp_role_ff   <= rsp_role_in;
      rsp_vote_ff   <= rsp_vote_in;
   end

   assign out_send_kind    = rsp_kind_ff;
   assign out_send_term    = rsp_sterm_ff;
   assign out_send_dest    = rsp_dest_ff;
   assign out_send_granted = rsp_grant_ff;
   assign out_report_valid = rsp_rvalid_ff;
   assign out_alive        = rsp_alive_ff;
   assign out_term_now     = rsp_term_ff;
   assign out_role_now     = rsp_role_ff;
   assign out_vote_now     = signed'(rsp_vote_ff);

endmodule

### hdl/raft_election_node_core.sv
// Top level of the raft election node core: controller plus datapath.
//
// One Raft server's leader-election engine. Each transaction on req_ch is one
// event (start, tick, request vote, vote reply, heartbeat, crash restart); each
// gives exactly one transaction on rsp_ch with the message to send and the
// node's report (term, role, vote). Channels use valid/ready; a transaction
// moves on a clock edge with both high.
// Configuration is a write-only port: csr_wr_en, csr_index, csr_wr_data. The
// user must write it only while no event is in flight; the block itself has
// no guard for this. Writing the seed reloads the splitmix64 generator.
// Every event passes the exec and done states; a vote reply that updates the
// tally adds the tally state; events that re-arm the election timer run the
// generator (one 32x32 multiplier runs three partial products for each of the
// two 64-bit multiplies, then the fin and mod states reduce the output mod 3).
// One event is in flight at a time; the next is accepted in the cycle after
// the previous response enters the output register, even if it still waits.
// Reset (synchronous) clears the election state and loads register defaults.
// A stalled receiver holds the response stable; the engine waits to load the
// next response until the output register is free.
module raft_election_node_core #(
   parameter int MAX_NODES  = rle_pkg::DEF_MAX_NODES,
   parameter int TERM_WIDTH = rle_pkg::DEF_TERM_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [rle_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rle_pkg::CSR_DATA_W-1:0] csr_wr_data,
   rle_req_if.sink                        req_ch,
   rle_rsp_if.source                      rsp_ch
);
   import rle_pkg::*;

   rle_cmd_type  cmd;
   rle_stat_type stat;

   // Sequencer
   rle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // State, evaluation and generator
   rle_dp #(
      .MAX_NODES  (MAX_NODES),
      .TERM_WIDTH (TERM_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .in_mode          (req_ch.mode),
      .in_msg_term      (req_ch.msg_term),
      .in_msg_node      (req_ch.msg_node),
      .in_msg_granted   (req_ch.msg_granted),
      .out_send_kind    (rsp_ch.send_kind),
      .out_send_term    (rsp_ch.send_term),
      .out_send_dest    (rsp_ch.send_dest),
      .out_send_granted (rsp_ch.send_granted),
      .out_report_valid (rsp_ch.report_valid),
      .out_alive        (rsp_ch.alive),
      .out_term_now     (rsp_ch.term_now),
      .out_role_now     (rsp_ch.role_now),
      .out_vote_now     (rsp_ch.vote_now),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

### hdl/rle_checker.sv
// Port-level checks of the raft election node core and their bind.
`include "raft_election_node_core_assert.svh"

module rle_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [rle_pkg::KIND_W-1:0]       send_kind,
   input logic [rle_pkg::TERM_PORT_W-1:0]  send_term,
   input logic [rle_pkg::NODE_W-1:0]       send_dest,
   input logic                             send_granted,
   input logic                             report_valid,
   input logic                             alive,
   input logic [rle_pkg::ROLE_W-1:0]       role_now,
   input logic signed [rle_pkg::VOTE_W-1:0] vote_now
);
   import rle_pkg::*;

   // a stalled response holds its message
   `RLE_ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(send_kind) && $stable(send_term) && $stable(send_dest))

   // no response right after reset
   `RLE_ASSERT_RST(a_rsp_reset, reset |=> !rsp_valid)

   // crash report: follower, nothing sent
   `RLE_ASSERT_CLK(a_crash_report, rsp_valid && !alive |-> report_valid && role_now == ROLE_FOL && send_kind == SEND_NONE)

   // nothing sent means empty message fields
   `RLE_ASSERT_CLK(a_none_empty, rsp_valid && send_kind == SEND_NONE |-> send_term == '0 && send_dest == '0 && !send_granted)

   // a granted vote is recorded for the candidate addressed
   `RLE_ASSERT_CLK(a_grant_vote, rsp_valid && send_granted |-> send_kind == SEND_VOTEREP && !vote_now[4] && vote_now[3:0] == send_dest)

endmodule

bind raft_election_node_core rle_checker u_rle_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .send_kind    (rsp_ch.send_kind),
   .send_term    (rsp_ch.send_term),
   .send_dest    (rsp_ch.send_dest),
   .send_granted (rsp_ch.send_granted),
   .report_valid (rsp_ch.report_valid),
   .alive        (rsp_ch.alive),
   .role_now     (rsp_ch.role_now),
   .vote_now     (rsp_ch.vote_now)
);
